[src/bfa_pkg.sv]
`default_nettype none

package bfa_pkg;

  // Fixed field widths
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int SIZE_W    = 32;
  localparam int ALIGN_W   = 4;
  localparam int BASE_W    = 32;
  localparam int ADDR_W    = 33;
  localparam int START_W   = 12;

  // Default sizing of the pool
  localparam int MAP_UNITS_DEF  = 4096;
  localparam int UNIT_BYTES_DEF = 64;
  localparam int POOL_BYTES_DEF = 262144;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_RUN_RD,
    ST_RUN_EV,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_ADDR_MUL,
    ST_ADDR_SUM,
    ST_PUSH_OK,
    ST_PUSH_FAIL
  } state_t;

  typedef struct packed {
    logic load_req;
    logic div_step;
    logic clr_wr;
    logic scan_next;
    logic rd_run;
    logic run_init;
    logic run_adv;
    logic mark_init;
    logic mark_wr;
    logic mul;
    logic sum;
    logic push_ok;
    logic push_fail;
  } cmd_t;

  typedef struct packed {
    logic rej;
    logic word_full;
    logic past_end;
    logic scan_last;
    logic conflict;
    logic run_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

[src/bitmap_first_fit_allocator_core.sv]
// First-fit bitmap allocator. The pool holds MAP_UNITS units of UNIT_BYTES
// bytes each, tracked by an occupancy bitmap of 32-bit words kept in a
// single-port-write, registered-read memory. After reset the block sweeps the
// bitmap to zero, one word per cycle; in_stall stays high during that sweep
// while cfg writes are taken as usual. Each request beat then goes through
// these steps: accept, check for refusal (no pool, zero size, size above
// POOL_BYTES), divide the rounded-up size by UNIT_BYTES with a constant
// reciprocal multiply, scan the bitmap words, check the words of each
// candidate run, mark the words of the run, form the address (unit index
// times UNIT_BYTES, then plus pool_base) and load the result beat, which
// waits while the output register is full. A request refused at the check
// goes straight to the result beat. Every scan, check and mark step is one
// read of the bitmap memory followed by one use.
// One request is in flight at a time; the result sits in an output register
// so a new request is taken while the previous result beat waits.
`default_nettype none

module bitmap_first_fit_allocator_core #(
  parameter int MAP_UNITS  = bfa_pkg::MAP_UNITS_DEF,
  parameter int UNIT_BYTES = bfa_pkg::UNIT_BYTES_DEF,
  parameter int POOL_BYTES = bfa_pkg::POOL_BYTES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // pool_base register
  input  wire logic                         cfg_we,
  input  wire logic [bfa_pkg::BASE_W-1:0]   cfg_wdata,
  // request channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [bfa_pkg::SIZE_W-1:0]   size_bytes,
  input  wire logic [bfa_pkg::ALIGN_W-1:0]  alignment_log2,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              granted,
  output logic [bfa_pkg::ADDR_W-1:0]        address,
  output logic [bfa_pkg::START_W-1:0]       start_unit
);

  bfa_pkg::cmd_t    cmd;
  bfa_pkg::status_t sts;

  // Sequencer: clear sweep, divide, scan, check, mark, address, push
  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Bitmap memory, divider, run masks, address math and result register
  bfa_dpath #(
    .MAP_UNITS  (MAP_UNITS),
    .UNIT_BYTES (UNIT_BYTES),
    .POOL_BYTES (POOL_BYTES)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .size_bytes     (size_bytes),
    .alignment_log2 (alignment_log2),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .granted        (granted),
    .address        (address),
    .start_unit     (start_unit)
  );

endmodule

`default_nettype wire

[src/bfa_ctrl.sv]
`default_nettype none

module bfa_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire bfa_pkg::status_t sts,
  output bfa_pkg::cmd_t        cmd
);

  bfa_pkg::state_t state;
  bfa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfa_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = 1'b1;
    case (state)
      bfa_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.scan_last) begin
          state_next = bfa_pkg::ST_IDLE;
        end
      end
      bfa_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = bfa_pkg::ST_CHECK;
        end
      end
      bfa_pkg::ST_CHECK: begin
        state_next = sts.rej ? bfa_pkg::ST_PUSH_FAIL : bfa_pkg::ST_DIV;
      end
      bfa_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        state_next   = bfa_pkg::ST_SCAN_RD;
      end
      bfa_pkg::ST_SCAN_RD: begin
        state_next = bfa_pkg::ST_SCAN_EV;
      end
      bfa_pkg::ST_SCAN_EV: begin
        if (sts.word_full) begin
          if (sts.scan_last) begin
            state_next = bfa_pkg::ST_PUSH_FAIL;
          end else begin
            cmd.scan_next = 1'b1;
            state_next    = bfa_pkg::ST_SCAN_RD;
          end
        end else if (sts.past_end) begin
          state_next = bfa_pkg::ST_PUSH_FAIL;
        end else begin
          cmd.run_init = 1'b1;
          state_next   = bfa_pkg::ST_RUN_RD;
        end
      end
      bfa_pkg::ST_RUN_RD: begin
        cmd.rd_run = 1'b1;
        state_next = bfa_pkg::ST_RUN_EV;
      end
      bfa_pkg::ST_RUN_EV: begin
        if (sts.conflict) begin
          if (sts.scan_last) begin
            state_next = bfa_pkg::ST_PUSH_FAIL;
          end else begin
            cmd.scan_next = 1'b1;
            state_next    = bfa_pkg::ST_SCAN_RD;
          end
        end else if (sts.run_last) begin
          cmd.mark_init = 1'b1;
          state_next    = bfa_pkg::ST_MARK_RD;
        end else begin
          cmd.run_adv = 1'b1;
          state_next  = bfa_pkg::ST_RUN_RD;
        end
      end
      bfa_pkg::ST_MARK_RD: begin
        cmd.rd_run = 1'b1;
        state_next = bfa_pkg::ST_MARK_WR;
      end
      bfa_pkg::ST_MARK_WR: begin
        cmd.mark_wr = 1'b1;
        if (sts.run_last) begin
          state_next = bfa_pkg::ST_ADDR_MUL;
        end else begin
          cmd.run_adv = 1'b1;
          state_next  = bfa_pkg::ST_MARK_RD;
        end
      end
      bfa_pkg::ST_ADDR_MUL: begin
        cmd.mul    = 1'b1;
        state_next = bfa_pkg::ST_ADDR_SUM;
      end
      bfa_pkg::ST_ADDR_SUM: begin
        cmd.sum    = 1'b1;
        state_next = bfa_pkg::ST_PUSH_OK;
      end
      bfa_pkg::ST_PUSH_OK: begin
        if (sts.out_free) begin
          cmd.push_ok = 1'b1;
          state_next  = bfa_pkg::ST_IDLE;
        end
      end
      bfa_pkg::ST_PUSH_FAIL: begin
        if (sts.out_free) begin
          cmd.push_fail = 1'b1;
          state_next    = bfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bfa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/bfa_dpath.sv]
`default_nettype none

module bfa_dpath #(
  parameter int MAP_UNITS  = bfa_pkg::MAP_UNITS_DEF,
  parameter int UNIT_BYTES = bfa_pkg::UNIT_BYTES_DEF,
  parameter int POOL_BYTES = bfa_pkg::POOL_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bfa_pkg::cmd_t                 cmd,
  output bfa_pkg::status_t                   sts,
  input  wire logic                          cfg_we,
  input  wire logic [bfa_pkg::BASE_W-1:0]    cfg_wdata,
  input  wire logic [bfa_pkg::SIZE_W-1:0]    size_bytes,
  input  wire logic [bfa_pkg::ALIGN_W-1:0]   alignment_log2,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  output logic                               granted,
  output logic [bfa_pkg::ADDR_W-1:0]         address,
  output logic [bfa_pkg::START_W-1:0]        start_unit
);

  localparam int WB        = bfa_pkg::WORD_BITS;
  localparam int MAP_WORDS = (MAP_UNITS + WB - 1) / WB;
  localparam int WA_W      = $clog2(MAP_WORDS);
  localparam int IDX_W     = WA_W + bfa_pkg::BIT_W;
  localparam int DVD_W     = $clog2(POOL_BYTES + UNIT_BYTES);
  localparam int UB_W      = $clog2(UNIT_BYTES + 1);
  localparam int RCP_SH    = DVD_W + $clog2(UNIT_BYTES);
  localparam int RCP_W     = DVD_W + 1;
  localparam int QP_W      = RCP_SH + DVD_W;
  localparam int SUM_W     = ((DVD_W > IDX_W) ? DVD_W : IDX_W) + 1;
  localparam int PROD_W    = IDX_W + UB_W;
  localparam int TAKE_W    = bfa_pkg::BIT_W + 1;
  localparam int AW        = bfa_pkg::ADDR_W;

  // Rounded-up reciprocal of the unit size, exact for every dividend below 2^DVD_W
  localparam longint RCP_L = ((longint'(1) << RCP_SH) + longint'(UNIT_BYTES) - 1) /
                             longint'(UNIT_BYTES);
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_L);

  // Bitmap memory, one word per 32 units
  logic [WB-1:0]   map_mem [MAP_WORDS];
  logic [WB-1:0]   rdata;
  logic            wr_en;
  logic [WA_W-1:0] wr_addr;
  logic [WB-1:0]   wr_data;
  logic [WA_W-1:0] rd_addr;

  logic [bfa_pkg::BASE_W-1:0]  pool_base;
  logic [bfa_pkg::ALIGN_W-1:0] align;
  logic                        rej;
  logic [DVD_W-1:0]            dvd;
  logic [WA_W-1:0]             scan_w;
  logic [WA_W-1:0]             run_w;
  logic [bfa_pkg::BIT_W-1:0]   lo;
  logic [DVD_W-1:0]            rem;
  logic [IDX_W-1:0]            start;
  logic [PROD_W-1:0]           prod;
  logic [AW-1:0]               base_sum;

  logic                        rej_c;
  logic [QP_W-1:0]             qprod;
  logic [bfa_pkg::BIT_W-1:0]   lowbit;
  logic [IDX_W-1:0]            start_c;
  logic [TAKE_W-1:0]           avail;
  logic [TAKE_W-1:0]           take;
  logic [WB-1:0]               mask_base;
  logic [WB-1:0]               mask;
  logic [AW-1:0]               amask;
  logic [AW-1:0]               aligned;

  assign rej_c = (pool_base == '0) || (size_bytes == '0) ||
                 (size_bytes > bfa_pkg::SIZE_W'(POOL_BYTES));

  // Divide by the unit size: multiply by the reciprocal and keep the high bits
  assign qprod = QP_W'(dvd) * QP_W'(RCP);

  // Lowest free bit of the word just read
  always_comb begin
    lowbit = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (!rdata[i]) begin
        lowbit = bfa_pkg::BIT_W'(i);
      end
    end
  end

  assign start_c = {scan_w, lowbit};

  // Slice of the run that falls in the current word
  assign avail     = TAKE_W'(WB) - TAKE_W'(lo);
  assign take      = (rem >= DVD_W'(avail)) ? avail : TAKE_W'(rem);
  assign mask_base = (take == TAKE_W'(WB)) ? '1 : ((WB'(1) << take) - WB'(1));
  assign mask      = mask_base << lo;

  assign amask   = (AW'(1) << align) - AW'(1);
  assign aligned = (base_sum + amask) & ~amask;

  assign sts.rej       = rej;
  assign sts.word_full = &rdata;
  assign sts.past_end  = (SUM_W'(start_c) + SUM_W'(dvd)) > SUM_W'(MAP_UNITS);
  assign sts.scan_last = scan_w == WA_W'(MAP_WORDS - 1);
  assign sts.conflict  = |(rdata & mask);
  assign sts.run_last  = rem == DVD_W'(take);
  assign sts.out_free  = !out_valid || !out_stall;

  assign wr_en   = cmd.clr_wr || cmd.mark_wr;
  assign wr_addr = cmd.clr_wr ? scan_w : run_w;
  assign wr_data = cmd.clr_wr ? '0 : (rdata | mask);
  assign rd_addr = cmd.rd_run ? run_w : scan_w;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    rdata <= map_mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
      scan_w    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        pool_base <= cfg_wdata;
      end
      if (cmd.load_req) begin
        scan_w <= '0;
      end else if (cmd.clr_wr || cmd.scan_next) begin
        scan_w <= scan_w + WA_W'(1);
      end
      if (cmd.push_ok || cmd.push_fail) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      align <= alignment_log2;
      rej   <= rej_c;
      dvd   <= DVD_W'(size_bytes) + DVD_W'(UNIT_BYTES - 1);
    end
    if (cmd.div_step) begin
      dvd <= qprod[RCP_SH +: DVD_W];
    end
    if (cmd.run_init) begin
      start <= start_c;
      run_w <= scan_w;
      lo    <= lowbit;
      rem   <= dvd;
    end
    if (cmd.mark_init) begin
      run_w <= start[IDX_W-1:bfa_pkg::BIT_W];
      lo    <= start[bfa_pkg::BIT_W-1:0];
      rem   <= dvd;
    end
    if (cmd.run_adv) begin
      run_w <= run_w + WA_W'(1);
      lo    <= '0;
      rem   <= rem - DVD_W'(take);
    end
    if (cmd.mul) begin
      prod <= PROD_W'(start) * PROD_W'(UNIT_BYTES);
    end
    if (cmd.sum) begin
      base_sum <= AW'(pool_base) + AW'(prod);
    end
    if (cmd.push_ok) begin
      granted    <= 1'b1;
      address    <= aligned;
      start_unit <= bfa_pkg::START_W'(start);
    end else if (cmd.push_fail) begin
      granted    <= 1'b0;
      address    <= '0;
      start_unit <= '0;
    end
  end

endmodule

`default_nettype wire

[src/bfa_checker.sv]
`default_nettype none

module bfa_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic                        granted,
  input wire logic [bfa_pkg::ADDR_W-1:0]  address,
  input wire logic [bfa_pkg::START_W-1:0] start_unit
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(granted) &&
      $stable(address) && $stable(start_unit))
    else $error("result beat changed while stalled");

  // A refused beat carries zero fields
  a_refuse_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !granted |-> address == '0 && start_unit == '0)
    else $error("refused beat with nonzero fields");

  // One request in flight: busy right after accepting
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  // Reset starts the clear sweep with no result pending
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("block open for requests right after reset");

endmodule

bind bitmap_first_fit_allocator_core bfa_checker u_bfa_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .granted    (granted),
  .address    (address),
  .start_unit (start_unit)
);

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps

// Self-checking bench for the first-fit bitmap allocator. Requests and result
// beats run over valid/stall handshakes with random gaps on both sides. Each
// accepted request is predicted on the spot against a private copy of the
// occupancy map and pool_base, and each result beat is checked in order.
module testbench;

  localparam int MAP_UNITS   = bfa_pkg::MAP_UNITS_DEF;
  localparam int UNIT_BYTES  = bfa_pkg::UNIT_BYTES_DEF;
  localparam int POOL_BYTES  = bfa_pkg::POOL_BYTES_DEF;
  localparam int LONG_HOLD   = 300;    // receiver hold-off in the backpressure test
  localparam int QUIET_LIMIT = 10000;  // cycles with no beat before giving up
  localparam int SETTLE      = 40;     // cycles to watch for stray beats at the end

  typedef struct packed {
    logic                         granted;
    logic [bfa_pkg::ADDR_W-1:0]   address;
    logic [bfa_pkg::START_W-1:0]  start_unit;
  } alloc_result_t;

  // Clock, reset and block inputs start at known values.
  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [bfa_pkg::BASE_W-1:0]   cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [bfa_pkg::SIZE_W-1:0]   size_bytes = '0;
  logic [bfa_pkg::ALIGN_W-1:0]  alignment_log2 = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         granted;
  logic [bfa_pkg::ADDR_W-1:0]   address;
  logic [bfa_pkg::START_W-1:0]  start_unit;

  // Private copy of the block state: one bit per unit, set when taken.
  logic [MAP_UNITS-1:0]        taken_units = '0;
  logic [bfa_pkg::BASE_W-1:0]  base_addr = '0;

  alloc_result_t expected_allocs[$];

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  logic long_hold_pending = 1'b0;
  int rx_wait = 0;
  int quiet_cycles = 0;

  int error_count = 0;
  int requests_sent = 0;
  int grants_sent = 0;
  int beats_checked = 0;
  int base_writes = 0;

  always #1 clk = ~clk;

  bitmap_first_fit_allocator_core DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .size_bytes     (size_bytes),
    .alignment_log2 (alignment_log2),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .granted        (granted),
    .address        (address),
    .start_unit     (start_unit)
  );

  // Predict one allocation and update the private map. Scan words in order; the
  // candidate start is the lowest free unit of the first word with any free
  // unit. Give up as soon as that run would cross the end of the map.
  function automatic alloc_result_t predict_alloc(
      input logic [bfa_pkg::SIZE_W-1:0] size,
      input logic [bfa_pkg::ALIGN_W-1:0] align_log2);
    alloc_result_t res;
    logic [63:0] units;
    logic [63:0] first;
    logic [63:0] addr;
    logic [63:0] amask;
    logic [bfa_pkg::WORD_BITS-1:0] free_bits;
    int lowest;
    bit run_clear;
    res = '0;
    if (base_addr == '0 || size == '0 || size > POOL_BYTES) return res;
    units = ({32'd0, size} + UNIT_BYTES - 1) / UNIT_BYTES;
    for (int w = 0; w < MAP_UNITS / bfa_pkg::WORD_BITS; w++) begin
      free_bits = ~taken_units[w * bfa_pkg::WORD_BITS +: bfa_pkg::WORD_BITS];
      if (free_bits == '0) continue;
      lowest = 0;
      while (!free_bits[lowest]) lowest++;
      first = w * bfa_pkg::WORD_BITS + lowest;
      if (first + units > MAP_UNITS) return res;
      run_clear = 1'b1;
      for (int k = 0; k < units; k++) begin
        if (taken_units[first + k]) begin
          run_clear = 1'b0;
          break;
        end
      end
      // A blocked run skips the rest of this word; go to the next word.
      if (!run_clear) continue;
      for (int k = 0; k < units; k++) taken_units[first + k] = 1'b1;
      amask = (64'd1 << align_log2) - 64'd1;
      addr = {32'd0, base_addr} + first * UNIT_BYTES;
      addr = (addr + amask) & ~amask;
      res.granted = 1'b1;
      res.address = addr[bfa_pkg::ADDR_W-1:0];
      res.start_unit = first[bfa_pkg::START_W-1:0];
      return res;
    end
    return res;
  endfunction

  // Offer one request beat after a random gap and hold it until taken. Keep
  // valid high across back-to-back beats; drop it only when a gap follows.
  task automatic send_request(input logic [bfa_pkg::SIZE_W-1:0] size,
                              input logic [bfa_pkg::ALIGN_W-1:0] align_log2);
    alloc_result_t prediction;
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    size_bytes <= size;
    alignment_log2 <= align_log2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    prediction = predict_alloc(size, align_log2);
    expected_allocs.push_back(prediction);
    requests_sent++;
    if (prediction.granted) grants_sent++;
  endtask

  // Stop offering and wait until every predicted beat has been checked. One
  // request yields exactly one beat, so the block is idle after the last one.
  task automatic finish_outstanding();
    in_valid <= 1'b0;
    while (expected_allocs.size() != 0) @(posedge clk);
  endtask

  // Write pool_base while the block is idle; the model takes it at the same edge.
  task automatic set_pool_base(input logic [bfa_pkg::BASE_W-1:0] value);
    finish_outstanding();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    base_addr = value;
    base_writes++;
  endtask

  // Mostly small requests so the map fills slowly, with some mid-size runs,
  // zero sizes, oversize values over the whole 32-bit range and the boundary
  // sizes around one to four units and around the pool size.
  function automatic logic [bfa_pkg::SIZE_W-1:0] random_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 72) return $urandom_range(1, 320);
    if (pick < 75) return $urandom_range(321, 4096);
    if (pick < 82) return '0;
    if (pick < 90) return $urandom_range(POOL_BYTES + 1, 32'hFFFF_FFFF);
    if (pick < 95) return POOL_BYTES + $urandom_range(0, 1);
    return UNIT_BYTES * $urandom_range(1, 4) + $urandom_range(0, 1);
  endfunction

  // Pool base still at its reset value of zero: everything is refused.
  task automatic test_no_pool();
    send_request(32'd64, 4'd0);
    send_request(32'd1, 4'd15);
    send_request(POOL_BYTES, 4'd12);
  endtask

  // Refused sizes, then the first grants from an empty map.
  task automatic test_special_sizes();
    set_pool_base(32'h1000_0000);
    send_request(32'd0, 4'd0);
    send_request(POOL_BYTES + 1, 4'd3);
    send_request(32'hFFFF_FFFF, 4'd15);
    send_request(32'h8000_0000, 4'd0);
    send_request(32'd1, 4'd0);
    send_request(32'd64, 4'd0);
    send_request(32'd65, 4'd0);
    send_request(32'd128, 4'd6);
  endtask

  // Alignment rounding, with the base at both extremes (the high one makes the sum
  // spill past 32 bits), and exponents above 12.
  task automatic test_alignment();
    set_pool_base(32'hFFFF_FFFF);
    send_request(32'd1, 4'd0);
    send_request(32'd10, 4'd1);
    send_request(32'd100, 4'd6);
    send_request(32'd64, 4'd12);
    send_request(32'd63, 4'd13);
    send_request(32'd200, 4'd15);
    set_pool_base(32'h0000_0001);
    send_request(32'd1, 4'd0);
    send_request(32'd2, 4'd7);
    send_request(32'd130, 4'd15);
    send_request(32'd3, 4'd14);
  endtask

  // Random traffic in segments, each with its own pool_base and idle pattern:
  // both sides idling, neither, sender only, receiver only.
  task automatic test_random_traffic();
    logic [bfa_pkg::BASE_W-1:0] base;
    for (int seg = 0; seg < 10; seg++) begin
      case (seg)
        0: base = 32'h0000_0001;
        3: base = 32'hFFFF_FFFF;
        6: base = '0;
        default: base = $urandom();
      endcase
      tx_idle = (seg % 4 == 0) || (seg % 4 == 2);
      rx_idle = (seg % 4 == 0) || (seg % 4 == 3);
      set_pool_base(base);
      for (int n = 0; n < 100; n++) send_request(random_size(), $urandom_range(0, 15));
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Hold the result channel for a long stretch while the sender keeps
  // offering back to back, so the output register fills and the input stalls.
  task automatic test_backpressure();
    set_pool_base(32'hA5A5_0000);
    tx_idle = 1'b0;
    long_hold_pending <= 1'b1;
    for (int n = 0; n < 8; n++) send_request($urandom_range(1, 192), $urandom_range(0, 15));
    tx_idle = 1'b1;
  endtask

  // Drive the map to its end: a run one unit too long, a whole-pool request,
  // chunks that use up the tail exactly, then requests against a full map.
  task automatic test_fill_to_end();
    int free_units;
    int chunk;
    set_pool_base($urandom() | 32'h0000_0040);
    free_units = MAP_UNITS - $countones(taken_units);
    send_request((free_units + 1) * UNIT_BYTES, $urandom_range(0, 15));
    send_request(POOL_BYTES, $urandom_range(0, 15));
    while (free_units > 0) begin
      chunk = $urandom_range(1, 400);
      if (chunk > free_units) chunk = free_units;
      send_request(chunk * UNIT_BYTES - $urandom_range(0, UNIT_BYTES - 1),
                   $urandom_range(0, 15));
      free_units = MAP_UNITS - $countones(taken_units);
    end
    for (int n = 0; n < 40; n++) send_request(random_size(), $urandom_range(0, 15));
  endtask

  // Check each accepted result beat against the oldest prediction.
  always @(posedge clk) begin : result_check
    alloc_result_t want;
    if (!rst && out_valid && !out_stall) begin
      beats_checked++;
      if (expected_allocs.size() == 0) begin
        $error("result beat with no request outstanding");
        error_count++;
      end else begin
        want = expected_allocs.pop_front();
        if (granted !== want.granted) begin
          $error("granted: expected %0d, got %0d", want.granted, granted);
          error_count++;
        end
        if (address !== want.address) begin
          $error("address: expected 0x%0h, got 0x%0h", want.address, address);
          error_count++;
        end
        if (start_unit !== want.start_unit) begin
          $error("start_unit: expected %0d, got %0d", want.start_unit, start_unit);
          error_count++;
        end
      end
    end
  end

  // Pace the result channel: after each beat, stall for a random gap when rx_idle
  // is set; on request, hold off for a long stretch counted here.
  always @(posedge clk) begin : result_pacing
    int gap;
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait <= 0;
    end else if (long_hold_pending) begin
      long_hold_pending <= 1'b0;
      out_stall <= 1'b1;
      rx_wait <= LONG_HOLD;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      if (rx_wait == 1) out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      gap = rx_idle ? $urandom_range(0, 15) : 0;
      rx_wait <= gap;
      out_stall <= (gap != 0);
    end
  end

  // End the run if no beat moves on either channel for too long.
  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("bitmap_first_fit_allocator_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // Release reset; the block then clears its map while holding its input
    // stalled, and the first request waits on that.
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_no_pool();
    test_special_sizes();
    test_alignment();
    test_random_traffic();
    test_backpressure();
    test_fill_to_end();

    finish_outstanding();
    repeat (SETTLE) @(posedge clk);

    $display("Ran %0d requests (%0d granted, %0d refused) across %0d pool_base settings,",
             requests_sent, grants_sent, requests_sent - grants_sent, base_writes);
    $display("map filled to %0d of %0d units, %0d result beats checked.",
             $countones(taken_units), MAP_UNITS, beats_checked);
    if (error_count == 0) begin
      $display("bitmap_first_fit_allocator_core test passed");
    end else begin
      $display("bitmap_first_fit_allocator_core test failed");
    end
    $finish;
  end

endmodule

[files.f]
src/bfa_pkg.sv
src/bfa_ctrl.sv
src/bfa_dpath.sv
src/bitmap_first_fit_allocator_core.sv
src/bfa_checker.sv
verif/testbench.sv
